[rtl/b64e_pkg.sv]
// Shared types, constants and the sextet-to-ASCII mapping for the base64 encoder.
package b64e_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3d;

    // Position within the current 3-byte group.
    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } phase_t;

    // One classified input byte: up to four characters to emit.
    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [3:0]      pad;
        logic [1:0]      last_idx;
        logic            fin;
    } job_t;

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            ch = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            ch = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            ch = 8'h2b;
        end else begin
            ch = 8'h2f;
        end
        return ch;
    endfunction

endpackage

[rtl/b64e_front.sv]
// Front end: accepts bytes, tracks the group position and builds character jobs.
module b64e_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_final_byte,
    input  logic            queue_full,
    output logic            push,
    output b64e_pkg::job_t  push_job
);
    import b64e_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    job_t       job;

    assign s_ready  = !queue_full;
    assign push     = s_valid && !queue_full;
    assign push_job = job;

    always_comb begin
        job        = '0;
        phase_next = phase_reg;
        left_next  = left_reg;
        job.fin    = s_final_byte;
        unique case (phase_reg)
            PHASE_1: begin
                job.sextet[0] = {left_reg[1:0], s_data_byte[7:4]};
                if (s_final_byte) begin
                    job.sextet[1] = {s_data_byte[3:0], 2'b00};
                    job.pad[2]    = 1'b1;
                    job.last_idx  = 2'd2;
                end else begin
                    job.last_idx = 2'd0;
                    phase_next   = PHASE_2;
                    left_next    = s_data_byte[3:0];
                end
            end
            PHASE_2: begin
                job.sextet[0] = {left_reg, s_data_byte[7:6]};
                job.sextet[1] = s_data_byte[5:0];
                job.last_idx  = 2'd1;
                phase_next    = PHASE_0;
                left_next     = 4'd0;
            end
            default: begin
                job.sextet[0] = s_data_byte[7:2];
                if (s_final_byte) begin
                    job.sextet[1] = {s_data_byte[1:0], 4'b0000};
                    job.pad[3:2]  = 2'b11;
                    job.last_idx  = 2'd3;
                end else begin
                    job.last_idx = 2'd0;
                    phase_next   = PHASE_1;
                    left_next    = {2'b00, s_data_byte[1:0]};
                end
            end
        endcase
        if (s_final_byte) begin
            phase_next = PHASE_0;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_0;
            left_reg  <= 4'd0;
        end else if (push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

[rtl/b64e_queue.sv]
// Small job queue that decouples the front end from the character emitter.
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  b64e_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output b64e_pkg::job_t  head_job
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/b64e_back.sv]
// Back end: walks each queued job and emits one character per cycle into an output register unless m_ready stalls it.
module b64e_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            empty,
    input  b64e_pkg::job_t  head_job,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_code_char,
    output logic            m_run_end,
    output logic            m_stream_end
);
    import b64e_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg, char_next;
    logic       run_end_reg, run_end_next;
    logic       stream_end_reg;
    logic       load;

    assign load         = !empty && (!valid_reg || m_ready);
    assign run_end_next = (idx_reg == head_job.last_idx);
    assign char_next    = head_job.pad[idx_reg] ? PAD_CHAR
                                                : sextet_to_ascii(head_job.sextet[idx_reg]);
    assign pop          = load && run_end_next;

    assign m_valid      = valid_reg;
    assign m_code_char  = char_reg;
    assign m_run_end    = run_end_reg;
    assign m_stream_end = stream_end_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg       <= char_next;
            run_end_reg    <= run_end_next;
            stream_end_reg <= run_end_next && head_job.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= run_end_next ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/base64_stream_encoder_top.sv]
// Top level of the streaming base64 encoder.
//
// The block encodes a byte stream into standard base64 characters (A-Z, a-z,
// 0-9, '+', '/'), one byte per input item and one character per result item.
// A byte in the first or second position of a 3-byte group gives one
// character, a byte in the third position gives two. A byte marked final
// flushes the partial group and pads with '=' to a multiple of four
// characters, so it may give up to four characters; after it the encoder
// starts a fresh group. m_run_end marks the last character caused by a byte,
// and m_stream_end marks the last character of a message.
//
// Timing: the front end takes a byte in any cycle in which its job queue has
// room, so bytes can arrive back to back until the queue fills. The emitter
// behind the queue produces one character per cycle while m_ready does not
// stall it, so a full group of three bytes gives four characters and a final
// byte up to four. A byte's job is written into the queue when the byte is
// accepted, and the output register then loads its first character from the
// queue head. The emitter stalls while a character waits in the output
// register for m_ready, and the queue lets the input side keep accepting
// bytes while the output side is stalled, until the queue fills.
module base64_stream_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_code_char,
    output logic       m_run_end,
    output logic       m_stream_end
);
    import b64e_pkg::*;

    // Jobs flow front end -> queue -> emitter.
    logic queue_full;
    logic queue_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    // Front end: holds the group position and leftover bits, and turns each
    // accepted byte into a job listing the characters it produces.
    b64e_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .queue_full   (queue_full),
        .push         (push),
        .push_job     (push_job)
    );

    // Short queue so that either side can stall without holding the other.
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head_job (head_job)
    );

    // Emitter: maps sextets to ASCII and hands out one character per cycle while m_ready allows.
    b64e_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (queue_empty),
        .head_job     (head_job),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_char  (m_code_char),
        .m_run_end    (m_run_end),
        .m_stream_end (m_stream_end)
    );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the streaming base64 encoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    // Standard base64 alphabet, index 0 in the most significant byte.
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // The least number of random bytes to send after the directed messages.
    localparam int RANDOM_BYTES = 110;

    // Once fewer than this many bytes are left to send, both sides stop idling.
    localparam int CALM_TAIL = 25;

    // The receiver stops for this many cycles once, after HOLD_AFTER characters.
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AFTER  = 60;

    // One byte waiting to be offered. drain_first makes the sender wait until
    // every character expected so far has come out before offering it.
    typedef struct {
        logic [7:0] data;
        logic       fin;
        logic       drain_first;
    } byte_item_t;

    // One character the encoder should produce.
    typedef struct {
        logic [7:0] code;
        logic       run_end;
        logic       stream_end;
    } char_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_final_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_code_char;
    logic       m_run_end;
    logic       m_stream_end;

    byte_item_t pending_bytes[$];
    char_item_t expected_chars[$];

    // Encoder state as the checker sees it.
    phase_t     enc_phase = PHASE_0;
    logic [3:0] enc_left = 4'h0;

    int mismatches = 0;
    int chars_seen = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_count = 0;
    bit hold_done = 1'b0;

    base64_stream_encoder_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_char  (m_code_char),
        .m_run_end    (m_run_end),
        .m_stream_end (m_stream_end)
    );

    always #10 aclk = ~aclk;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return ALPHABET[8*(63 - v) +: 8];
    endfunction

    function automatic void push_char(input logic [7:0] code, input logic last,
                                      input logic fin);
        char_item_t c;
        c.code = code;
        c.run_end = last;
        c.stream_end = last & fin;
        expected_chars.push_back(c);
    endfunction

    // Works out the characters that one accepted byte causes and advances the
    // group position. A phase that never occurs is taken as the first one.
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        case (enc_phase)
            PHASE_1: begin
                push_char(sextet_char({enc_left[1:0], b[7:4]}), !fin, fin);
                if (fin) begin
                    push_char(sextet_char({b[3:0], 2'b00}), 1'b0, fin);
                    push_char(PAD_CHAR, 1'b1, fin);
                end else begin
                    enc_left = b[3:0];
                    enc_phase = PHASE_2;
                end
            end
            PHASE_2: begin
                push_char(sextet_char({enc_left, b[7:6]}), 1'b0, fin);
                push_char(sextet_char(b[5:0]), 1'b1, fin);
                enc_left = 4'h0;
                enc_phase = PHASE_0;
            end
            default: begin
                push_char(sextet_char(b[7:2]), !fin, fin);
                if (fin) begin
                    push_char(sextet_char({b[1:0], 4'h0}), 1'b0, fin);
                    push_char(PAD_CHAR, 1'b0, fin);
                    push_char(PAD_CHAR, 1'b1, fin);
                end else begin
                    enc_left = {2'b00, b[1:0]};
                    enc_phase = PHASE_1;
                end
            end
        endcase
        if (fin) begin
            enc_phase = PHASE_0;
            enc_left = 4'h0;
        end
    endfunction

    task automatic queue_byte(input logic [7:0] data, input logic fin,
                              input logic drain_first);
        byte_item_t it;
        it.data = data;
        it.fin = fin;
        it.drain_first = drain_first;
        pending_bytes.push_back(it);
    endtask

    // Sender. A byte stays on the bus until it is accepted; between bytes the
    // sender may idle for a short burst, or wait for the output to drain.
    always @(posedge aclk) begin
        logic       next_valid;
        logic [7:0] next_data;
        logic       next_fin;
        bit         calm;
        next_valid = s_valid;
        next_data = s_data_byte;
        next_fin = s_final_byte;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encode_byte(s_data_byte, s_final_byte);
                void'(pending_bytes.pop_front());
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                calm = (pending_bytes.size() < CALM_TAIL);
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() == 0) begin
                    next_valid = 1'b0;
                end else if (pending_bytes[0].drain_first && expected_chars.size() != 0) begin
                    next_valid = 1'b0;
                end else if (!calm && $urandom_range(0, 3) == 0) begin
                    // Idle: start a random gap before the next byte.
                    send_gap = $urandom_range(0, 6);
                end else begin
                    next_valid = 1'b1;
                    next_data = pending_bytes[0].data;
                    next_fin = pending_bytes[0].fin;
                end
            end
        end else begin
            next_valid = 1'b0;
        end
        s_valid <= next_valid;
        s_data_byte <= next_data;
        s_final_byte <= next_fin;
    end

    // Receiver. Every accepted character is checked against the oldest one
    // expected. Ready drops in short random bursts, and once for a long hold
    // so that the encoder's queue fills and it stops taking bytes.
    always @(posedge aclk) begin
        char_item_t want;
        logic       next_ready;
        bit         calm;
        next_ready = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected character: code %h run_end %b stream_end %b",
                                 m_code_char, m_run_end, m_stream_end);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_code_char !== want.code || m_run_end !== want.run_end ||
                        m_stream_end !== want.stream_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"character %0d mismatch: expected code %h run_end %b ",
                                      "stream_end %b, got code %h run_end %b stream_end %b"},
                                     chars_seen, want.code, want.run_end, want.stream_end,
                                     m_code_char, m_run_end, m_stream_end);
                    end
                end
            end
            calm = (pending_bytes.size() < CALM_TAIL);
            if (hold_count > 0) begin
                hold_count--;
            end else if (!hold_done && chars_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_count = HOLD_CYCLES - 1;
            end else if (recv_gap > 0) begin
                recv_gap--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                recv_gap = $urandom_range(0, 6);
            end else begin
                next_ready = 1'b1;
            end
        end
        m_ready <= next_ready;
    end

    // Stimulus and end of run.
    initial begin
        int sent;
        int len;
        bit pause_mid;
        sent = 0;
        pause_mid = 1'b0;

        // Single-byte messages: all zeros and all ones, each padded with two '='.
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hff, 1'b1, 1'b0);
        // Two-byte messages, padded with one '='.
        queue_byte(8'hff, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b1, 1'b0);
        // A full group that ends the message: no padding, all '/'.
        queue_byte(8'hff, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b1, 1'b0);
        // Four bytes: a full group, then a final byte that starts a new one.
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hff, 1'b0, 1'b0);
        queue_byte(8'haa, 1'b0, 1'b0);
        queue_byte(8'h55, 1'b1, 1'b0);
        // Five bytes: a group of all '+', then two bytes with final in the
        // second position.
        queue_byte(8'hfb, 1'b0, 1'b0);
        queue_byte(8'hef, 1'b0, 1'b0);
        queue_byte(8'hbe, 1'b0, 1'b0);
        queue_byte(8'h12, 1'b0, 1'b0);
        queue_byte(8'h34, 1'b1, 1'b0);

        // Random messages, mostly short. The first random byte, and one about
        // halfway, wait until the output side has drained.
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) < 7)
                len = $urandom_range(1, 6);
            else
                len = $urandom_range(7, 16);
            for (int i = 0; i < len; i++) begin
                queue_byte(8'($urandom_range(0, 255)), (i == len - 1),
                           (sent == 0) || (i == 0 && !pause_mid && sent >= 55));
                if (i == 0 && sent >= 55)
                    pause_mid = 1'b1;
                sent++;
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_chars.size() != 0)
            @(posedge aclk);
        // Let any stray characters show up before the verdict.
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule
